// ----- design/spectrum_bin_to_pixel_max_hold_unit_defines.svh -----
// Assertion macros for the spectrum bin to pixel max-hold unit.
// Included by the checker; depends on nothing else.
`ifndef SPECTRUM_BIN_TO_PIXEL_MAX_HOLD_UNIT_DEFINES_SVH
`define SPECTRUM_BIN_TO_PIXEL_MAX_HOLD_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SBPMH_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define SBPMH_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// Next-cycle implication that is also checked across reset.
`define SBPMH_ASSERT_NEXT_ALWAYS(label, clk, ante, cons, msg) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- design/sbpmh_pkg.sv -----
// Shared types and constants of the spectrum bin to pixel max-hold unit.
// Used by the channel interfaces, the top level and the checker.
`timescale 1ns / 1ps

package sbpmh_pkg;

  localparam int DISPLAY_PIXELS_DEF  = 240;
  localparam int EXCLUSION_SLOTS_DEF = 4;
  localparam int SLICE_POSITIONS     = 256;
  localparam int MAP_CROSSOVER       = 120;
  localparam int UPPER_END           = 240;
  localparam int BURST_LIMIT         = 64;
  localparam int BURST_W             = 7;

  localparam int POS_W   = 8;
  localparam int POW_W   = 8;
  localparam int PIX_W   = 8;
  localparam int STEP_W  = 30;
  localparam int START_W = 33;
  localparam int BIN_W   = 27;
  localparam int RAD_W   = 27;
  localparam int EXCL_W  = 33;
  localparam int ACC_W   = 31;
  localparam int FREQ_W  = 38;
  localparam int ALU_W   = 40;

  localparam int CFG_W     = 33;
  localparam int CFG_IDX_W = 3;

  localparam logic [STEP_W-1:0]  PIXEL_STEP_RST = 30'd78125;
  localparam logic [START_W-1:0] START_FREQ_RST = 33'd2400000000;
  localparam logic [BIN_W-1:0]   BIN_WIDTH_RST  = 27'd78125;

  localparam logic FUNC_RESTART = 1'b0;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PIXEL_STEP,
    REG_START_FREQ,
    REG_BIN_WIDTH,
    REG_EXCL_RADIUS,
    REG_EXCL_0,
    REG_EXCL_1,
    REG_EXCL_2,
    REG_EXCL_3
  } cfg_reg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ADD,
    ST_CMP,
    ST_XDIFF,
    ST_XRAD,
    ST_LAST,
    ST_EMIT
  } state_t;

endpackage

// ----- design/sbpmh_if.sv -----
// Valid/ready channel interfaces for sample requests and pixel results.
// Depends on sbpmh_pkg for the field widths.
`timescale 1ns / 1ps

interface sbpmh_in_if import sbpmh_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             func;
  logic [POS_W-1:0] slice_position;
  logic [POW_W-1:0] power_db;

  modport source (output valid, func, slice_position, power_db, input ready);
  modport sink   (input valid, func, slice_position, power_db, output ready);
endinterface

interface sbpmh_out_if import sbpmh_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] pixel_number;
  logic [POW_W-1:0] pixel_power;
  logic             masked;
  logic             last_of_run;

  modport source (output valid, pixel_number, pixel_power, masked, last_of_run, input ready);
  modport sink   (input valid, pixel_number, pixel_power, masked, last_of_run, output ready);
endinterface

// ----- design/spectrum_bin_to_pixel_max_hold_unit.sv -----
// Max-hold decimator from spectrum slice positions to display pixels; one request at a time.
// A restart or skipped request is taken in the idle state; a sample steps through add and compare.
// Each pixel then steps through the exclusion slots, a last-of-run check and an emit state that
// waits for the result; the wide sums share one 40-bit adder.
// Reset is synchronous and active low; all registers but slot, mask, last and diff are reset.
// Depends on sbpmh_pkg and the channel interfaces in sbpmh_if.sv.
`timescale 1ns / 1ps

module spectrum_bin_to_pixel_max_hold_unit import sbpmh_pkg::*; #(
  parameter int DISPLAY_PIXELS  = DISPLAY_PIXELS_DEF,
  parameter int EXCLUSION_SLOTS = EXCLUSION_SLOTS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  sbpmh_in_if.sink             in_ch,
  sbpmh_out_if.source          out_ch,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata
);

  localparam int CNT_W  = $clog2(DISPLAY_PIXELS + 1);
  localparam int SLOT_W = (EXCLUSION_SLOTS > 1) ? $clog2(EXCLUSION_SLOTS) : 1;

  logic [STEP_W-1:0]  step_r;
  logic [START_W-1:0] start_r;
  logic [BIN_W-1:0]   bin_r;
  logic [RAD_W-1:0]   radius_r;
  logic [EXCL_W-1:0]  excl_r [EXCLUSION_SLOTS];

  state_t             state_r,  state_nxt;
  logic [CNT_W-1:0]   count_r,  count_nxt;
  logic [POW_W-1:0]   max_r,    max_nxt;
  logic [ACC_W-1:0]   acc_r,    acc_nxt;
  logic [FREQ_W-1:0]  freq_r,   freq_nxt;
  logic [BURST_W-1:0] burst_r,  burst_nxt;
  logic [SLOT_W-1:0]  slot_r,   slot_nxt;
  logic               masked_r, masked_nxt;
  logic               last_r,   last_nxt;
  logic [ALU_W-1:0]   diff_r,   diff_nxt;

  logic [STEP_W-1:0]  step_eff;
  logic [CNT_W:0]     count_ext;
  logic [CNT_W:0]     count_inc;
  logic [CNT_W+7:0]   count_pix;
  logic [BURST_W-1:0] burst_inc;
  logic [POS_W:0]     pos_ext;
  logic               display_full;
  logic               pos_skip;
  logic [EXCL_W-1:0]  excl_cur;
  logic               slot_last;
  logic [ALU_W-1:0]   alu_a, alu_b, alu_res;
  logic               alu_sub;
  logic               alu_neg;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r   <= PIXEL_STEP_RST;
      start_r  <= START_FREQ_RST;
      bin_r    <= BIN_WIDTH_RST;
      radius_r <= '0;
      for (int i = 0; i < EXCLUSION_SLOTS; i++) begin
        excl_r[i] <= '0;
      end
    end else if (cfg_we) begin
      case (cfg_index)
        REG_PIXEL_STEP:  step_r   <= cfg_wdata[STEP_W-1:0];
        REG_START_FREQ:  start_r  <= cfg_wdata[START_W-1:0];
        REG_BIN_WIDTH:   bin_r    <= cfg_wdata[BIN_W-1:0];
        REG_EXCL_RADIUS: radius_r <= cfg_wdata[RAD_W-1:0];
        default: begin
          for (int i = 0; i < EXCLUSION_SLOTS; i++) begin
            if (cfg_index == CFG_IDX_W'(int'(REG_EXCL_0) + i)) begin
              excl_r[i] <= cfg_wdata[EXCL_W-1:0];
            end
          end
        end
      endcase
    end
  end

  assign step_eff     = (step_r == '0) ? STEP_W'(1) : step_r;
  assign count_ext    = {1'b0, count_r};
  assign count_inc    = count_ext + (CNT_W+1)'(1);
  assign count_pix    = {8'b0, count_r};
  assign burst_inc    = burst_r + BURST_W'(1);
  assign pos_ext      = {1'b0, in_ch.slice_position};
  assign display_full = count_ext >= (CNT_W+1)'(DISPLAY_PIXELS);
  assign pos_skip     = (pos_ext >= (POS_W+1)'(SLICE_POSITIONS)) ||
                        ((pos_ext >= (POS_W+1)'(UPPER_END)) &&
                         (pos_ext >= (POS_W+1)'(MAP_CROSSOVER)));
  assign excl_cur     = excl_r[slot_r];
  assign slot_last    = slot_r == SLOT_W'(EXCLUSION_SLOTS - 1);

  // Shared adder: operand selection by sequencer state.
  always_comb begin
    alu_a   = ALU_W'(acc_r);
    alu_b   = ALU_W'(step_eff);
    alu_sub = 1'b1;
    case (state_r)
      ST_ADD: begin
        alu_b   = ALU_W'(bin_r);
        alu_sub = 1'b0;
      end
      ST_XDIFF: begin
        alu_a = ALU_W'(freq_r);
        alu_b = ALU_W'(excl_cur);
      end
      ST_XRAD: begin
        if (diff_r[ALU_W-1]) begin
          alu_a   = diff_r;
          alu_b   = ALU_W'(radius_r);
          alu_sub = 1'b0;
        end else begin
          alu_a = ALU_W'(radius_r);
          alu_b = diff_r;
        end
      end
      ST_EMIT: begin
        alu_a   = ALU_W'(freq_r);
        alu_sub = 1'b0;
      end
      default: begin
        alu_sub = 1'b1;
      end
    endcase
  end

  assign alu_res = alu_a + (alu_b ^ {ALU_W{alu_sub}}) + ALU_W'(alu_sub);
  assign alu_neg = alu_res[ALU_W-1];

  always_comb begin
    state_nxt  = state_r;
    count_nxt  = count_r;
    max_nxt    = max_r;
    acc_nxt    = acc_r;
    freq_nxt   = freq_r;
    burst_nxt  = burst_r;
    slot_nxt   = slot_r;
    masked_nxt = masked_r;
    last_nxt   = last_r;
    diff_nxt   = diff_r;
    case (state_r)
      ST_IDLE: begin
        if (in_ch.valid) begin
          if (in_ch.func == FUNC_RESTART) begin
            count_nxt = '0;
            max_nxt   = '0;
            acc_nxt   = '0;
            freq_nxt  = FREQ_W'(start_r);
          end else if (!pos_skip && !display_full) begin
            if (in_ch.power_db > max_r) begin
              max_nxt = in_ch.power_db;
            end
            state_nxt = ST_ADD;
          end
        end
      end
      ST_ADD: begin
        acc_nxt   = (alu_res[ALU_W-1:ACC_W] != '0) ? '1 : alu_res[ACC_W-1:0];
        burst_nxt = '0;
        state_nxt = ST_CMP;
      end
      ST_CMP: begin
        if (!alu_neg && !display_full && (burst_r < BURST_W'(BURST_LIMIT))) begin
          acc_nxt    = alu_res[ACC_W-1:0];
          slot_nxt   = '0;
          masked_nxt = 1'b0;
          state_nxt  = ST_XDIFF;
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      ST_XDIFF: begin
        if ((excl_cur == '0) || masked_r) begin
          if (slot_last) begin
            state_nxt = ST_LAST;
          end else begin
            slot_nxt = slot_r + SLOT_W'(1);
          end
        end else begin
          diff_nxt  = alu_res;
          state_nxt = ST_XRAD;
        end
      end
      ST_XRAD: begin
        masked_nxt = !alu_neg;
        if (slot_last) begin
          state_nxt = ST_LAST;
        end else begin
          slot_nxt  = slot_r + SLOT_W'(1);
          state_nxt = ST_XDIFF;
        end
      end
      ST_LAST: begin
        last_nxt  = alu_neg || (count_inc >= (CNT_W+1)'(DISPLAY_PIXELS)) ||
                    (burst_inc >= BURST_W'(BURST_LIMIT));
        state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        if (out_ch.ready) begin
          freq_nxt  = (alu_res[ALU_W-1:FREQ_W] != '0) ? '1 : alu_res[FREQ_W-1:0];
          count_nxt = count_inc[CNT_W-1:0];
          max_nxt   = '0;
          burst_nxt = burst_inc;
          state_nxt = last_r ? ST_IDLE : ST_CMP;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      count_r <= '0;
      max_r   <= '0;
      acc_r   <= '0;
      freq_r  <= '0;
      burst_r <= '0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      max_r   <= max_nxt;
      acc_r   <= acc_nxt;
      freq_r  <= freq_nxt;
      burst_r <= burst_nxt;
    end
    slot_r   <= slot_nxt;
    masked_r <= masked_nxt;
    last_r   <= last_nxt;
    diff_r   <= diff_nxt;
  end

  assign in_ch.ready         = state_r == ST_IDLE;
  assign out_ch.valid        = state_r == ST_EMIT;
  assign out_ch.pixel_number = count_pix[PIX_W-1:0];
  assign out_ch.pixel_power  = max_r;
  assign out_ch.masked       = masked_r;
  assign out_ch.last_of_run  = last_r;

endmodule

// ----- design/sbpmh_checker.sv -----
// Port-level checker for the spectrum bin to pixel max-hold unit, with its bind.
// Depends on sbpmh_pkg and the macros in the defines header.
`timescale 1ns / 1ps
`include "spectrum_bin_to_pixel_max_hold_unit_defines.svh"

module sbpmh_checker import sbpmh_pkg::*; (
  input logic             clk,
  input logic             rst_n,
  input logic             in_ready,
  input logic             out_valid,
  input logic             out_ready,
  input logic [PIX_W-1:0] out_pixel_number,
  input logic [POW_W-1:0] out_pixel_power,
  input logic             out_masked,
  input logic             out_last
);

  `SBPMH_ASSERT_NEXT_ALWAYS(a_ready_after_reset, clk, !rst_n, in_ready, "not ready after reset")

  `SBPMH_ASSERT_NOW(a_one_request, clk, rst_n, out_valid, !in_ready, "request taken while a pixel is pending")

  `SBPMH_ASSERT_NEXT(a_ready_after_last, clk, rst_n, out_valid && out_ready && out_last, in_ready, "not ready after the final pixel of a run")

  `SBPMH_ASSERT_NEXT(a_stall_holds, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_pixel_number) && $stable(out_pixel_power) && $stable(out_masked) && $stable(out_last), "stalled pixel changed")

endmodule

bind spectrum_bin_to_pixel_max_hold_unit sbpmh_checker u_sbpmh_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_ready         (in_ch.ready),
  .out_valid        (out_ch.valid),
  .out_ready        (out_ch.ready),
  .out_pixel_number (out_ch.pixel_number),
  .out_pixel_power  (out_ch.pixel_power),
  .out_masked       (out_ch.masked),
  .out_last         (out_ch.last_of_run)
);

// ----- sim/tb_spectrum_bin_to_pixel_max_hold_unit.sv -----
// Self-checking testbench for the spectrum bin to pixel max-hold unit: directed and random
// sample requests against a scoreboard that predicts every pixel of the result channel.
// Depends on sbpmh_pkg, the channel interfaces in sbpmh_if.sv and the unit itself.
`timescale 1ns / 1ps

module tb_spectrum_bin_to_pixel_max_hold_unit import sbpmh_pkg::*; ();

  localparam logic FUNC_SAMPLE = 1'b1;
  localparam int GUARD_CYCLES = 24;
  localparam int HOLD_CYCLES = 300;
  localparam int TIMEOUT_NS = 10_000_000;
  localparam logic [ACC_W-1:0] ACC_MAX = '1;
  localparam logic [FREQ_W-1:0] FREQ_MAX = '1;

  typedef struct packed {
    logic [PIX_W-1:0] number;
    logic [POW_W-1:0] power;
    logic             masked;
    logic             is_last;
  } pixel_t;

  class max_hold_predictor;
    logic [STEP_W-1:0]  step_hz;
    logic [START_W-1:0] start_hz;
    logic [BIN_W-1:0]   bin_hz;
    logic [RAD_W-1:0]   radius_hz;
    logic [EXCL_W-1:0]  excl_hz [EXCLUSION_SLOTS_DEF];
    logic [PIX_W-1:0]   pixel_count;
    logic [POW_W-1:0]   peak;
    logic [ACC_W-1:0]   acc_hz;
    logic [FREQ_W-1:0]  freq_hz;
    pixel_t             pending_pixels [$];
    int                 mismatches;

    function new();
      step_hz     = PIXEL_STEP_RST;
      start_hz    = START_FREQ_RST;
      bin_hz      = BIN_WIDTH_RST;
      radius_hz   = '0;
      foreach (excl_hz[i]) excl_hz[i] = '0;
      pixel_count = '0;
      peak        = '0;
      acc_hz      = '0;
      freq_hz     = '0;
      mismatches  = 0;
    endfunction

    function void set_reg(cfg_reg_t idx, logic [CFG_W-1:0] val);
      case (idx)
        REG_PIXEL_STEP:  step_hz = val[STEP_W-1:0];
        REG_START_FREQ:  start_hz = val[START_W-1:0];
        REG_BIN_WIDTH:   bin_hz = val[BIN_W-1:0];
        REG_EXCL_RADIUS: radius_hz = val[RAD_W-1:0];
        REG_EXCL_0:      excl_hz[0] = val[EXCL_W-1:0];
        REG_EXCL_1:      excl_hz[1] = val[EXCL_W-1:0];
        REG_EXCL_2:      excl_hz[2] = val[EXCL_W-1:0];
        REG_EXCL_3:      excl_hz[3] = val[EXCL_W-1:0];
        default: ;
      endcase
    endfunction

    function bit in_band(logic [FREQ_W-1:0] f);
      logic [FREQ_W-1:0] centre, radius, lo, hi;
      radius = FREQ_W'(radius_hz);
      for (int i = 0; i < EXCLUSION_SLOTS_DEF; i++) begin
        centre = FREQ_W'(excl_hz[i]);
        if (centre == '0) continue;
        lo = (centre > radius) ? centre - radius : '0;
        hi = centre + radius;
        if (f >= lo && f <= hi) return 1'b1;
      end
      return 1'b0;
    endfunction

    function void take_request(logic func, logic [POS_W-1:0] pos, logic [POW_W-1:0] pwr);
      logic [ACC_W:0]   acc_sum;
      logic [ACC_W-1:0] step;
      logic [FREQ_W:0]  freq_sum;
      pixel_t           px;
      int               n;
      if (func == FUNC_RESTART) begin
        pixel_count = '0;
        peak        = '0;
        acc_hz      = '0;
        freq_hz     = FREQ_W'(start_hz);
        return;
      end
      if (pos >= SLICE_POSITIONS || (pos >= UPPER_END && pos >= MAP_CROSSOVER)) return;
      if (pixel_count >= DISPLAY_PIXELS_DEF) return;
      if (pwr > peak) peak = pwr;
      acc_sum = acc_hz + bin_hz;
      acc_hz = (acc_sum > ACC_MAX) ? ACC_MAX : acc_sum[ACC_W-1:0];
      step = (step_hz == '0) ? ACC_W'(1) : ACC_W'(step_hz);
      n = 0;
      px = '0;
      while (acc_hz >= step && pixel_count < DISPLAY_PIXELS_DEF && n < BURST_LIMIT) begin
        if (n > 0) pending_pixels.push_back(px);
        px.number  = pixel_count;
        px.power   = peak;
        px.masked  = in_band(freq_hz);
        px.is_last = 1'b0;
        n++;
        pixel_count++;
        peak = '0;
        acc_hz = acc_hz - step;
        freq_sum = freq_hz + step;
        freq_hz = (freq_sum > FREQ_MAX) ? FREQ_MAX : freq_sum[FREQ_W-1:0];
      end
      if (n > 0) begin
        px.is_last = 1'b1;
        pending_pixels.push_back(px);
      end
    endfunction

    task report_mismatch(string what, longint unsigned got_v, longint unsigned want_v);
      $display("%0t ns: mismatch on %s: got %0d, expected %0d", $time, what, got_v, want_v);
      mismatches++;
    endtask

    task check_pixel(logic [PIX_W-1:0] number, logic [POW_W-1:0] power, logic masked,
                     logic is_last);
      pixel_t want;
      if (pending_pixels.size() == 0) begin
        report_mismatch("pixel with none outstanding, number", number, 0);
        return;
      end
      want = pending_pixels.pop_front();
      if (number !== want.number) report_mismatch("pixel_number", number, want.number);
      if (power !== want.power) report_mismatch("pixel_power", power, want.power);
      if (masked !== want.masked) report_mismatch("masked", masked, want.masked);
      if (is_last !== want.is_last) report_mismatch("last_of_run", is_last, want.is_last);
    endtask
  endclass

  logic                 clk = 1'b0;
  logic                 rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_wdata;
  int                   sender_idle_pct = 0;
  int                   stall_pct = 0;
  int                   hold_left = 0;
  max_hold_predictor    sb;

  sbpmh_in_if  in_ch ();
  sbpmh_out_if out_ch ();

  spectrum_bin_to_pixel_max_hold_unit u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        out_ch.ready = 1'b0;
        hold_left--;
      end else begin
        out_ch.ready = ($urandom_range(0, 99) >= stall_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready)
      sb.check_pixel(out_ch.pixel_number, out_ch.pixel_power, out_ch.masked,
                     out_ch.last_of_run);
  end

  initial begin
    #TIMEOUT_NS;
    $display("spectrum_bin_to_pixel_max_hold_unit test failed");
    $finish;
  end

  task automatic write_reg(cfg_reg_t idx, logic [CFG_W-1:0] val);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_wdata = val;
    sb.set_reg(idx, val);
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  task automatic send_request(logic func, logic [POS_W-1:0] pos, logic [POW_W-1:0] pwr);
    while ($urandom_range(0, 99) < sender_idle_pct) begin
      in_ch.valid = 1'b0;
      @(negedge clk);
    end
    in_ch.valid          = 1'b1;
    in_ch.func           = func;
    in_ch.slice_position = pos;
    in_ch.power_db       = pwr;
    do @(posedge clk); while (!in_ch.ready);
    sb.take_request(func, pos, pwr);
    @(negedge clk);
  endtask

  task automatic settle();
    in_ch.valid = 1'b0;
    while (sb.pending_pixels.size() != 0) @(negedge clk);
    repeat (GUARD_CYCLES) @(negedge clk);
  endtask

  task automatic random_requests(int count);
    int unsigned pos;
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(0, 99) < 7) begin
        send_request(FUNC_RESTART, POS_W'($urandom_range(0, 255)),
                     POW_W'($urandom_range(0, 255)));
      end else begin
        pos = ($urandom_range(0, 9) == 0) ? $urandom_range(UPPER_END, 255)
                                          : $urandom_range(0, UPPER_END - 1);
        send_request(FUNC_SAMPLE, POS_W'(pos), POW_W'($urandom_range(0, 255)));
      end
    end
  endtask

  task automatic random_config(int unsigned step_max);
    int unsigned     step_v;
    longint unsigned start_v, centre_v;
    step_v  = $urandom_range(1, step_max);
    start_v = {$urandom_range(0, 1), $urandom()};
    write_reg(REG_PIXEL_STEP, CFG_W'(step_v));
    write_reg(REG_START_FREQ, CFG_W'(start_v));
    write_reg(REG_BIN_WIDTH, CFG_W'($urandom_range(1, 2 * step_v)));
    write_reg(REG_EXCL_RADIUS, CFG_W'($urandom_range(0, 2 * step_v)));
    for (int i = 0; i < EXCLUSION_SLOTS_DEF; i++) begin
      centre_v = ($urandom_range(0, 3) == 0) ? 0 : start_v + step_v * $urandom_range(0, 60);
      write_reg(cfg_reg_t'(REG_EXCL_0 + i), CFG_W'(centre_v));
    end
  endtask

  initial begin
    sb = new();
    rst_n                = 1'b0;
    cfg_we               = 1'b0;
    cfg_index            = REG_PIXEL_STEP;
    cfg_wdata            = '0;
    in_ch.valid          = 1'b0;
    in_ch.func           = FUNC_RESTART;
    in_ch.slice_position = '0;
    in_ch.power_db       = '0;
    repeat (9) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // Before the first restart, pixel frequencies count up from zero.
    write_reg(REG_EXCL_0, 33'd156250);
    write_reg(REG_EXCL_1, 33'd2400078125);
    send_request(FUNC_SAMPLE, 8'd0, 8'd0);
    send_request(FUNC_SAMPLE, 8'd255, 8'd255);
    send_request(FUNC_SAMPLE, 8'd240, 8'd200);
    send_request(FUNC_SAMPLE, 8'd239, 8'd255);
    send_request(FUNC_SAMPLE, 8'd120, 8'd17);
    send_request(FUNC_SAMPLE, 8'd119, 8'd128);
    send_request(FUNC_RESTART, 8'd255, 8'd255);
    send_request(FUNC_SAMPLE, 8'd1, 8'd1);
    send_request(FUNC_SAMPLE, 8'd2, 8'd254);
    settle();

    // A zero step acts as one: bursts are capped and the display fills up.
    write_reg(REG_PIXEL_STEP, '0);
    write_reg(REG_BIN_WIDTH, 33'd200);
    write_reg(REG_START_FREQ, '0);
    write_reg(REG_EXCL_RADIUS, 33'd20);
    write_reg(REG_EXCL_0, 33'd30);
    write_reg(REG_EXCL_1, 33'd5);
    write_reg(REG_EXCL_2, '0);
    write_reg(REG_EXCL_3, 33'd8000000000);
    send_request(FUNC_RESTART, 8'd0, 8'd0);
    for (int i = 0; i < 6; i++) send_request(FUNC_SAMPLE, 8'(i * 40), 8'(255 - i));
    send_request(FUNC_RESTART, 8'd7, 8'd9);
    send_request(FUNC_SAMPLE, 8'd5, 8'd99);
    settle();

    // All-ones writes are cut to each register's width.
    write_reg(REG_PIXEL_STEP, '1);
    write_reg(REG_BIN_WIDTH, '1);
    write_reg(REG_EXCL_RADIUS, '1);
    write_reg(REG_START_FREQ, '1);
    write_reg(REG_EXCL_0, '1);
    write_reg(REG_EXCL_1, '0);
    write_reg(REG_EXCL_3, '0);
    send_request(FUNC_RESTART, 8'd0, 8'd0);
    for (int i = 0; i < 9; i++) send_request(FUNC_SAMPLE, 8'(i * 13), 8'(i * 31));
    settle();

    random_config(100000);
    send_request(FUNC_RESTART, 8'd0, 8'd0);
    random_requests(18);
    settle();

    sender_idle_pct = 53;
    random_config(1000);
    send_request(FUNC_RESTART, 8'd0, 8'd0);
    random_requests(18);
    settle();

    sender_idle_pct = 0;
    stall_pct = 53;
    random_config(4);
    write_reg(REG_BIN_WIDTH, CFG_W'($urandom_range(4, 24)));
    send_request(FUNC_RESTART, 8'd0, 8'd0);
    random_requests(16);
    settle();

    // The new start frequency is not taken until the next restart request.
    sender_idle_pct = 33;
    stall_pct = 33;
    random_config(50000);
    random_requests(14);
    settle();

    sender_idle_pct = 0;
    stall_pct = 0;
    random_config(1000);
    send_request(FUNC_RESTART, 8'd0, 8'd0);
    hold_left = HOLD_CYCLES;
    random_requests(12);
    settle();

    if (sb.pending_pixels.size() != 0)
      sb.report_mismatch("pixels never produced", sb.pending_pixels.size(), 0);
    if (sb.mismatches == 0) begin
      $display("spectrum_bin_to_pixel_max_hold_unit test passed");
    end else begin
      $display("spectrum_bin_to_pixel_max_hold_unit test failed");
    end
    $finish;
  end

endmodule
